>>> rtl/core/sha1md_pkg.sv
package sha1md_pkg;

	localparam int unsigned ROUNDS = 80;
	localparam int unsigned RND_W  = 7;
	localparam int unsigned WORDS  = 16;

	localparam logic [31:0] K_ROUND0 = 32'h5a827999;
	localparam logic [31:0] K_ROUND1 = 32'h6ed9eba1;
	localparam logic [31:0] K_ROUND2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_ROUND3 = 32'hca62c1d6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	// Round variables a..e, also used for the chaining value.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} vars_t;

	localparam vars_t IV = vars_t'{
		a: 32'h67452301,
		b: 32'hefcdab89,
		c: 32'h98badcfe,
		d: 32'h10325476,
		e: 32'hc3d2e1f0
	};

	// Commands to the message schedule window.
	typedef struct packed {
		logic load;	// shift in a freshly packed message word
		logic step;	// shift in the next expanded schedule word
	} sched_cmd_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

>>> rtl/core/sha1md_sched.sv
module sha1md_sched (
	input  logic                    clk,
	input  sha1md_pkg::sched_cmd_t  cmd,
	input  logic [31:0]             load_word,
	output logic [31:0]             w_cur
);
	import sha1md_pkg::*;

	// Rolling window: w_q[0] is the word used by the current round.
	logic [31:0] w_q [WORDS];
	logic [31:0] w_new;

	assign w_new = rotl32(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);
	assign w_cur = w_q[0];

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.step) begin
			for (int i = 0; i < WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[WORDS - 1] <= cmd.load ? load_word : w_new;
		end
	end

endmodule

>>> rtl/core/sha1md_round.sv
module sha1md_round (
	input  logic [sha1md_pkg::RND_W-1:0] rnd,
	input  sha1md_pkg::vars_t            cur,
	input  logic [31:0]                  w,
	output sha1md_pkg::vars_t            nxt
);
	import sha1md_pkg::*;

	logic [31:0] f;
	logic [31:0] k;

	// Pick the round function and constant by round group.
	always_comb begin
		priority if (rnd < RND_W'(20)) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = K_ROUND0;
		end else if (rnd < RND_W'(40)) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_ROUND1;
		end else if (rnd < RND_W'(60)) begin
			f = (cur.b & cur.c) ^ (cur.b & cur.d) ^ (cur.c & cur.d);
			k = K_ROUND2;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = K_ROUND3;
		end
	end

	always_comb begin
		nxt.a = rotl32(cur.a, 5) + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = rotl32(cur.b, 30);
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

>>> rtl/core/sha1_message_digest.sv
// SHA-1 digest of a byte stream.
//
// Input channel (in_valid / in_stall): one transaction per message byte.
// has_byte qualifies data_byte; last_byte ends the message after this
// transaction. A transaction with has_byte low and last_byte high ends an
// empty message; one with both low changes nothing.
// Output channel (out_valid / out_stall): five transactions per message,
// digest words a..e with word_index 0..4; last_word marks word e.
//
// Timing: a byte that does not complete a 64-byte block is taken at once.
// A byte that completes a block holds in_stall high for the 80 rounds
// through the single round unit and the fold into the chaining value.
// After the last transaction the padding is fed one byte per cycle
// (9 to 72 bytes) with one or two more compressions, then the five
// digest words are offered one per cycle while out_stall is low.
// The input is stalled for the whole time a message is finished and its
// digest is out; a stalled output simply holds the current word.
// Reset (arst_n low) loads the initial vector and clears the length and
// byte position; the block is ready for bytes as soon as reset is released.
module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import sha1md_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_COMP = 5'b00010,
		S_FIN  = 5'b00100,
		S_PAD  = 5'b01000,
		S_OUT  = 5'b10000
	} state_t;

	state_t             state_q;
	vars_t              chain_q;
	vars_t              wv_q;
	vars_t              wv_nxt;
	logic [63:0]        bits_q;
	logic [5:0]         pos_q;
	logic [23:0]        pack_q;
	logic [RND_W-1:0]   rnd_q;
	logic [2:0]         idx_q;
	logic               mark_q;	// 0x80 already appended
	logic               len_q;	// length bytes under way
	// A last byte that fills a block must resume padding after compression.
	logic               pad_req_q;

	logic               in_acc;
	logic               out_acc;
	logic               put_en;
	logic [7:0]         put_byte;
	logic [7:0]         pad_byte;
	logic [31:0]        w_cur;
	sched_cmd_t         sched_cmd;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid && !out_stall;

	// Padding byte: marker, zeros up to slot 56, then the length big-endian.
	always_comb begin
		priority if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (len_q || pos_q == 6'd56) begin
			pad_byte = bits_q[{~pos_q[2:0], 3'b000} +: 8];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign put_en   = (in_acc && has_byte) || (state_q == S_PAD);
	assign put_byte = (state_q == S_PAD) ? pad_byte : data_byte;

	// Push a full word into the schedule window on its fourth byte.
	assign sched_cmd.load = put_en && (pos_q[1:0] == 2'd3);
	assign sched_cmd.step = (state_q == S_COMP);

	sha1md_sched u_sched (
		.clk       (clk),
		.cmd       (sched_cmd),
		.load_word ({pack_q, put_byte}),
		.w_cur     (w_cur)
	);

	sha1md_round u_round (
		.rnd (rnd_q),
		.cur (wv_q),
		.w   (w_cur),
		.nxt (wv_nxt)
	);

	always_ff @(posedge clk) begin
		if (put_en) begin
			pack_q <= {pack_q[15:0], put_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			chain_q <= IV;
			wv_q    <= '0;
			bits_q  <= '0;
			pos_q   <= '0;
			rnd_q   <= '0;
			idx_q   <= '0;
			mark_q  <= 1'b0;
			len_q   <= 1'b0;
		end else begin
			if (put_en) begin
				pos_q <= pos_q + 6'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (has_byte) begin
							bits_q <= bits_q + 64'd8;
						end
						// Block full: start compression, padding follows if last.
						if (has_byte && pos_q == 6'd63) begin
							wv_q    <= chain_q;
							rnd_q   <= '0;
							state_q <= S_COMP;
						end else if (last_byte) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					mark_q <= 1'b1;
					if (mark_q && pos_q == 6'd56) begin
						len_q <= 1'b1;
					end
					if (pos_q == 6'd63) begin
						wv_q    <= chain_q;
						rnd_q   <= '0;
						state_q <= S_COMP;
					end
				end
				S_COMP: begin
					wv_q  <= wv_nxt;
					rnd_q <= rnd_q + RND_W'(1);
					if (rnd_q == RND_W'(ROUNDS - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					chain_q.a <= chain_q.a + wv_q.a;
					chain_q.b <= chain_q.b + wv_q.b;
					chain_q.c <= chain_q.c + wv_q.c;
					chain_q.d <= chain_q.d + wv_q.d;
					chain_q.e <= chain_q.e + wv_q.e;
					// Return to padding, to the digest, or to new bytes.
					priority if (len_q) begin
						idx_q   <= '0;
						state_q <= S_OUT;
					end else if (mark_q || pad_req_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (out_acc) begin
						if (idx_q == 3'd4) begin
							// Start a fresh message.
							chain_q <= IV;
							bits_q  <= '0;
							pos_q   <= '0;
							mark_q  <= 1'b0;
							len_q   <= 1'b0;
							idx_q   <= '0;
							state_q <= S_IDLE;
						end else begin
							idx_q <= idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_req_q <= 1'b0;
		end else if (in_acc && last_byte) begin
			pad_req_q <= 1'b1;
		end else if (state_q == S_PAD) begin
			pad_req_q <= 1'b0;
		end
	end

	always_comb begin
		unique case (idx_q)
			3'd0:    digest_word = chain_q.a;
			3'd1:    digest_word = chain_q.b;
			3'd2:    digest_word = chain_q.c;
			3'd3:    digest_word = chain_q.d;
			default: digest_word = chain_q.e;
		endcase
	end

	assign word_index = idx_q;
	assign last_word  = (idx_q == 3'd4);

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> idx_q <= 3'd4)
		else $error("digest word index out of range");

	a_comp_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_COMP) |-> rnd_q == '0)
		else $error("compression started at nonzero round");

	a_msg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && last_word) |=> (pos_q == '0 && bits_q == '0 && !mark_q))
		else $error("message state not cleared after digest");

	a_block_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_COMP) |-> pos_q == '0)
		else $error("compression started off a block boundary");

endmodule
